### rtl/core/fgn2d_pkg.sv
// Package for the fractal gradient noise block: hash constants, fixed-point
// constants and register map. No dependencies.
package fgn2d_pkg;

   localparam logic [31:0] HASH_C1 = 32'd3284157443;
   localparam logic [31:0] HASH_C2 = 32'd1911520717;
   localparam logic [31:0] HASH_C3 = 32'd2048419325;

   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] Q30_ONE     = 64'd1073741824;

   localparam int BASE_W  = 13;
   localparam int OCT_W   = 4;
   localparam int HEIGHT_W = 16;
   localparam int CSR_AW  = 3;
   localparam int CSR_DW  = 32;

   localparam logic REG_BASE_FREQ   = 1'b0;
   localparam logic REG_OCTAVE_CNT  = 1'b1;

   localparam logic [BASE_W-1:0] BASE_RESET = 13'd64;
   localparam logic [OCT_W-1:0]  OCT_RESET  = 4'd4;

endpackage

### rtl/core/fractal_gradient_noise_2d_top.sv
// Fractal 2-D gradient noise, one grid point per item, octaves summed.
// Depends on fgn2d_pkg.
//
// Usage: drive req_x_pos/req_y_pos and pulse start while busy is low; the
// item is taken on that edge and busy stays high until the result is out.
// rsp_valid is high for one cycle with rsp_height (Q1.14, within +-1).
// The two lattice divisions run on one restoring divider (one quotient bit a
// cycle), then each octave runs on one shared 34x33 multiplier (smoothstep,
// four corner hashes and dot products, three blends).
// One item at a time. The receiver cannot stall: the result is presented
// for exactly one cycle. Reset returns the sequencer to idle and loads
// base_frequency = 64 and octave_count = 4. Registers: base_frequency at
// byte address 0, octave_count at 4; write them only while idle.
module fractal_gradient_noise_2d_top #(
   parameter int CHUNK_SIZE  = 16,
   parameter int MAX_OCTAVES = 8,
   parameter int ANGLE_BITS  = 10
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [$clog2(CHUNK_SIZE)-1:0]      req_x_pos,
   input  logic [$clog2(CHUNK_SIZE)-1:0]      req_y_pos,
   output logic                              rsp_valid,
   output logic signed [fgn2d_pkg::HEIGHT_W-1:0] rsp_height,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [fgn2d_pkg::CSR_AW-1:0]       paddr,
   input  logic [fgn2d_pkg::CSR_DW-1:0]       pwdata,
   output logic [fgn2d_pkg::CSR_DW-1:0]       prdata,
   output logic                              pready
);
   import fgn2d_pkg::*;

   localparam int PW  = $clog2(CHUNK_SIZE);
   localparam int NW  = PW + MAX_OCTAVES - 1 + 16;
   localparam int DCW = $clog2(NW);
   localparam int CW  = $clog2(MAX_OCTAVES + 1);
   localparam int QB  = ANGLE_BITS - 2;
   localparam int QN  = 2 ** QB;

   // reciprocals of the series divisors (n+1)(n+2), rounded up
   localparam int RCP_S = 48;
   localparam logic [63:0] RCP_ONE = 64'd1 << RCP_S;
   typedef logic [63:0] rcp_type [16];
   localparam rcp_type RCP = '{
      (RCP_ONE + 64'd1) / 64'd2,     (RCP_ONE + 64'd5) / 64'd6,
      (RCP_ONE + 64'd11) / 64'd12,   (RCP_ONE + 64'd19) / 64'd20,
      (RCP_ONE + 64'd29) / 64'd30,   (RCP_ONE + 64'd41) / 64'd42,
      (RCP_ONE + 64'd55) / 64'd56,   (RCP_ONE + 64'd71) / 64'd72,
      (RCP_ONE + 64'd89) / 64'd90,   (RCP_ONE + 64'd109) / 64'd110,
      (RCP_ONE + 64'd131) / 64'd132, (RCP_ONE + 64'd155) / 64'd156,
      (RCP_ONE + 64'd181) / 64'd182, (RCP_ONE + 64'd209) / 64'd210,
      (RCP_ONE + 64'd239) / 64'd240, (RCP_ONE + 64'd271) / 64'd272
   };

   typedef logic [14:0] qrom_type [QN];

   function automatic qrom_type build_rom(input bit odd);
      qrom_type rom;
      logic [63:0] phi, x2, term, n;
      logic [127:0] prod;
      longint sum;
      for (int r = 0; r < QN; r++) begin
         phi  = (64'(r) * HALF_PI_Q30) >> QB;
         x2   = (phi * phi) >> 30;
         term = odd ? phi : Q30_ONE;
         sum  = longint'(term);
         n    = odd ? 64'd1 : 64'd0;
         for (int k = 0; k < 8; k++) begin
            prod = 128'((term * x2) >> 30) * 128'(RCP[n[3:0]]);
            term = 64'(prod >> RCP_S);
            n = n + 64'd2;
            if ((k & 1) == 1) sum = sum + longint'(term);
            else sum = sum - longint'(term);
         end
         if (sum < 0) sum = 0;
         if (sum > longint'(Q30_ONE)) sum = longint'(Q30_ONE);
         rom[r] = 15'((64'(sum) + 64'd32768) >> 16);
      end
      return rom;
   endfunction

   localparam qrom_type SIN_ROM = build_rom(1'b1);
   localparam qrom_type COS_ROM = build_rom(1'b0);

   typedef enum logic [4:0] {
      S_IDLE, S_DIV, S_OCT,
      S_SM0, S_SM1, S_SM2, S_SM3, S_SM4,
      S_H0, S_H1, S_H2, S_H3, S_H4, S_H5, S_H6,
      S_B0, S_B1, S_B2, S_B3, S_B4, S_B5, S_B6, S_B7,
      S_ACC, S_DONE
   } state_type;

   state_type state_ff;

   logic [BASE_W-1:0] base_ff;
   logic [OCT_W-1:0]  octave_ff;

   logic [PW-1:0]     yp_ff;
   logic [NW-1:0]     dq_ff, xq_ff, yq_ff;
   logic [BASE_W-1:0] rem_ff;
   logic [DCW-1:0]    dc_ff;
   logic              dsel_ff;
   logic [CW-1:0]     cnt_ff, oct_ff;
   logic [31:0]       x0_ff, x1_ff, y0_ff, y1_ff, ha_ff;
   logic [15:0]       fx_ff, fy_ff;
   logic [16:0]       wx_ff, wy_ff;
   logic [1:0]        cn_ff;
   logic signed [15:0] gx_ff, gy_ff;
   logic signed [32:0] t_ff, top_ff, bot_ff, noise_ff;
   logic signed [32:0] dot_ff [4];
   logic signed [33:0] df_ff;
   logic signed [49:0] p_ff;
   logic signed [31:0] sum_ff;
   logic              rsp_valid_ff;
   logic signed [HEIGHT_W-1:0] rsp_height_ff;

   // divider step
   logic [BASE_W-1:0] base_eff;
   logic [BASE_W:0]   dtmp;
   logic              dge;
   logic [NW-1:0]     dq_next;
   logic [BASE_W-1:0] rem_next;

   assign base_eff = (base_ff == '0) ? BASE_W'(1) : base_ff;
   assign dtmp     = {rem_ff, dq_ff[NW-1]};
   assign dge      = dtmp >= {1'b0, base_eff};
   assign rem_next = dge ? BASE_W'(dtmp - {1'b0, base_eff}) : BASE_W'(dtmp);
   assign dq_next  = {dq_ff[NW-2:0], dge};

   // per-octave lattice position
   logic [NW-1:0] xs, ys;
   assign xs = xq_ff >> (CW'(MAX_OCTAVES - 1) - oct_ff);
   assign ys = yq_ff >> (CW'(MAX_OCTAVES - 1) - oct_ff);

   // corner selection
   logic [31:0]        cx, cy;
   logic signed [17:0] dx, dy;
   assign cx = cn_ff[0] ? x1_ff : x0_ff;
   assign cy = cn_ff[1] ? y1_ff : y0_ff;
   assign dx = cn_ff[0] ? $signed({2'b11, fx_ff}) : $signed({2'b00, fx_ff});
   assign dy = cn_ff[1] ? $signed({2'b11, fy_ff}) : $signed({2'b00, fy_ff});

   // gradient lookup
   logic [ANGLE_BITS-1:0] gk;
   logic [1:0]            gq;
   logic [QB-1:0]         gr;
   logic signed [15:0]    gs, gc, gx_in, gy_in;
   assign gk = p_ff[31 -: ANGLE_BITS];
   assign gq = gk[ANGLE_BITS-1 -: 2];
   assign gr = gk[QB-1:0];
   assign gs = $signed({1'b0, SIN_ROM[gr]});
   assign gc = $signed({1'b0, COS_ROM[gr]});

   always_comb begin
      case (gq)
         2'd0: begin gx_in = gs;  gy_in = gc;  end
         2'd1: begin gx_in = gc;  gy_in = -gs; end
         2'd2: begin gx_in = -gs; gy_in = -gc; end
         default: begin gx_in = -gc; gy_in = gs; end
      endcase
   end

   // shared multiplier
   logic signed [33:0] mul_a;
   logic signed [32:0] mul_b;
   logic [31:0]        hp;
   assign hp = p_ff[31:0];

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         S_SM0: begin
            mul_a = $signed(34'(fx_ff));
            mul_b = $signed(33'(fx_ff));
         end
         S_SM1: begin
            mul_a = $signed(34'(p_ff[31:16]));
            mul_b = $signed(33'(18'd196608 - {1'b0, fx_ff, 1'b0}));
         end
         S_SM2: begin
            mul_a = $signed(34'(fy_ff));
            mul_b = $signed(33'(fy_ff));
         end
         S_SM3: begin
            mul_a = $signed(34'(p_ff[31:16]));
            mul_b = $signed(33'(18'd196608 - {1'b0, fy_ff, 1'b0}));
         end
         S_H0: begin
            mul_a = $signed({2'b00, cx});
            mul_b = $signed({1'b0, HASH_C1});
         end
         S_H1: begin
            mul_a = $signed({2'b00, cy ^ {hp[15:0], hp[31:16]}});
            mul_b = $signed({1'b0, HASH_C2});
         end
         S_H2: begin
            mul_a = $signed({2'b00, ha_ff ^ {hp[15:0], hp[31:16]}});
            mul_b = $signed({1'b0, HASH_C3});
         end
         S_H4: begin
            mul_a = 34'(dx);
            mul_b = 33'(gx_ff);
         end
         S_H5: begin
            mul_a = 34'(dy);
            mul_b = 33'(gy_ff);
         end
         S_B1, S_B3: begin
            mul_a = df_ff;
            mul_b = $signed(33'(wx_ff));
         end
         S_B6: begin
            mul_a = df_ff;
            mul_b = $signed(33'(wy_ff));
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   logic signed [49:0] p_in;
   logic signed [33:0] ph;
   logic signed [32:0] term;
   logic signed [34:0] sum_wide;
   assign p_in     = 50'(mul_a) * 50'(mul_b);
   assign ph       = 34'(p_ff >>> 16);
   assign term     = noise_ff >>> oct_ff;
   assign sum_wide = 35'(sum_ff) + 35'(term);

   localparam logic signed [34:0] SUM_MAX = 35'sd1073741824;
   localparam logic signed [34:0] SUM_MIN = -35'sd1073741824;

   always_ff @(posedge clock) begin
      p_ff <= p_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= (state_ff == S_DONE);
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  dq_ff   <= {req_x_pos, (NW-PW)'(0)};
                  yp_ff   <= req_y_pos;
                  rem_ff  <= '0;
                  dc_ff   <= '0;
                  dsel_ff <= 1'b0;
                  oct_ff  <= '0;
                  sum_ff  <= '0;
                  if (32'(octave_ff) > MAX_OCTAVES) cnt_ff <= CW'(MAX_OCTAVES);
                  else cnt_ff <= CW'(octave_ff);
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               if (dc_ff == DCW'(NW - 1)) begin
                  dc_ff  <= '0;
                  rem_ff <= '0;
                  if (!dsel_ff) begin
                     xq_ff   <= dq_next;
                     dq_ff   <= {yp_ff, (NW-PW)'(0)};
                     dsel_ff <= 1'b1;
                  end else begin
                     yq_ff <= dq_next;
                     state_ff <= (cnt_ff == '0) ? S_DONE : S_OCT;
                  end
               end else begin
                  dq_ff  <= dq_next;
                  rem_ff <= rem_next;
                  dc_ff  <= dc_ff + 1'b1;
               end
            end
            S_OCT: begin
               x0_ff <= 32'(xs[NW-1:16]);
               x1_ff <= 32'(xs[NW-1:16]) + 32'd1;
               y0_ff <= 32'(ys[NW-1:16]);
               y1_ff <= 32'(ys[NW-1:16]) + 32'd1;
               fx_ff <= xs[15:0];
               fy_ff <= ys[15:0];
               state_ff <= S_SM0;
            end
            S_SM0: state_ff <= S_SM1;
            S_SM1: state_ff <= S_SM2;
            S_SM2: begin
               wx_ff <= p_ff[32:16];
               state_ff <= S_SM3;
            end
            S_SM3: state_ff <= S_SM4;
            S_SM4: begin
               wy_ff <= p_ff[32:16];
               cn_ff <= '0;
               state_ff <= S_H0;
            end
            S_H0: state_ff <= S_H1;
            S_H1: begin
               ha_ff <= hp;
               state_ff <= S_H2;
            end
            S_H2: state_ff <= S_H3;
            S_H3: begin
               gx_ff <= gx_in;
               gy_ff <= gy_in;
               state_ff <= S_H4;
            end
            S_H4: state_ff <= S_H5;
            S_H5: begin
               t_ff <= 33'(p_ff);
               state_ff <= S_H6;
            end
            S_H6: begin
               dot_ff[cn_ff] <= t_ff + 33'(p_ff);
               cn_ff <= cn_ff + 1'b1;
               state_ff <= (cn_ff == 2'd3) ? S_B0 : S_H0;
            end
            S_B0: begin
               df_ff <= 34'(dot_ff[1]) - 34'(dot_ff[0]);
               state_ff <= S_B1;
            end
            S_B1: state_ff <= S_B2;
            S_B2: begin
               top_ff <= 33'(34'(dot_ff[0]) + ph);
               df_ff  <= 34'(dot_ff[3]) - 34'(dot_ff[2]);
               state_ff <= S_B3;
            end
            S_B3: state_ff <= S_B4;
            S_B4: begin
               bot_ff <= 33'(34'(dot_ff[2]) + ph);
               state_ff <= S_B5;
            end
            S_B5: begin
               df_ff <= 34'(bot_ff) - 34'(top_ff);
               state_ff <= S_B6;
            end
            S_B6: state_ff <= S_B7;
            S_B7: begin
               noise_ff <= 33'(34'(top_ff) + ph);
               state_ff <= S_ACC;
            end
            S_ACC: begin
               if (sum_wide > SUM_MAX) sum_ff <= 32'(SUM_MAX);
               else if (sum_wide < SUM_MIN) sum_ff <= 32'(SUM_MIN);
               else sum_ff <= 32'(sum_wide);
               if (oct_ff + 1'b1 == cnt_ff) begin
                  state_ff <= S_DONE;
               end else begin
                  oct_ff   <= oct_ff + 1'b1;
                  state_ff <= S_OCT;
               end
            end
            S_DONE: begin
               rsp_height_ff <= HEIGHT_W'(sum_ff >>> 16);
               state_ff      <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // configuration registers
   logic csr_wr;
   assign csr_wr = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff   <= BASE_RESET;
         octave_ff <= OCT_RESET;
      end else if (csr_wr) begin
         unique case (paddr[2])
            REG_BASE_FREQ:  base_ff   <= pwdata[BASE_W-1:0];
            REG_OCTAVE_CNT: octave_ff <= pwdata[OCT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_BASE_FREQ:  prdata = CSR_DW'(base_ff);
         REG_OCTAVE_CNT: prdata = CSR_DW'(octave_ff);
         default:        prdata = '0;
      endcase
   end

   assign pready     = 1'b1;
   assign busy       = (state_ff != S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_height = rsp_height_ff;

   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without item in flight");

   a_height_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_height <= 16'sd16384 && rsp_height >= -16'sd16384))
      else $error("height outside +-1");

   a_sum_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DONE |-> (sum_ff <= 32'sd1073741824 && sum_ff >= -32'sd1073741824))
      else $error("octave sum not clamped");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("item accepted without going busy");

endmodule
